// ===== hw/rtl/acr_pkg.sv =====
package acr_pkg;

  typedef enum logic [2:0] {
    ACT_LOOKUP = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_QUEUE  = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    KIND_LOOKUP = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_QUEUE  = 3'd2,
    KIND_SEND   = 3'd3,
    KIND_UNREACH = 3'd4,
    KIND_TICK   = 3'd5,
    KIND_ACK    = 3'd6
  } kind_e;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_TRIES   = 1'b1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam logic [3:0]  TRIES_RESET   = 4'd5;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic        full_res;
    logic [31:0] result_ip;
    logic [47:0] result_mac;
    logic [6:0]  pending_count;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/acr_cmd_if.sv =====
interface acr_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;
  modport source (output valid, action, ip_addr, mac_addr, input ready);
  modport sink   (input valid, action, ip_addr, mac_addr, output ready);
endinterface

// ===== hw/rtl/acr_res_if.sv =====
interface acr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        hit;
  logic        full_res;
  logic [31:0] result_ip;
  logic [47:0] result_mac;
  logic [6:0]  pending_count;
  logic        last;
  modport source (output valid, kind, hit, full_res, result_ip, result_mac,
                  pending_count, last, input ready);
  modport sink   (input valid, kind, hit, full_res, result_ip, result_mac,
                  pending_count, last, output ready);
endinterface

// ===== hw/rtl/acr_cfg_if.sv =====
interface acr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/acr_cmd_fifo.sv =====
// Two-entry transaction queue between front and back end.
module acr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  acr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output acr_pkg::cmd_t data_o
);
  acr_pkg::cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ===== hw/rtl/acr_front.sv =====
// Accepts transactions and passes the action through unchanged; unknown codes
// are answered by the back end with a single ack result.
module acr_front (
  acr_cmd_if.sink        cmd,
  input  logic           fifo_full_i,
  output logic           push_o,
  output acr_pkg::cmd_t  data_o
);
  assign cmd.ready = ~fifo_full_i;
  assign push_o    = cmd.valid & ~fifo_full_i;
  always_comb begin
    data_o.action   = cmd.action;
    data_o.ip_addr  = cmd.ip_addr;
    data_o.mac_addr = cmd.mac_addr;
  end
endmodule

// ===== hw/rtl/acr_back.sv =====
// Executes one transaction at a time by scanning the tables slot by slot.
module acr_back #(
  parameter int ENTRY_SLOTS   = 32,
  parameter int REQUEST_SLOTS = 8,
  parameter int MAX_PENDING   = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  acr_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  input  logic [15:0]    timeout_i,
  input  logic [3:0]     tries_i,
  acr_res_if.source      res
);
  localparam int EW = $clog2(ENTRY_SLOTS);
  localparam int RW = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
  localparam logic [6:0] MAXP = 7'(MAX_PENDING);

  typedef enum logic [2:0] {
    S_IDLE, S_ESCAN, S_ERD, S_RSCAN, S_EMIT, S_TICKR
  } state_e;

  state_e state_q;
  acr_pkg::cmd_t cmd_q;
  logic [EW:0] ei_q;
  logic [RW:0] ri_q;
  logic ehit_q, efree_q;
  logic [EW-1:0] eslot_q, efree_slot_q;
  logic rhit_q, rfree_q;
  logic [RW-1:0] rslot_q, rfree_slot_q;
  logic [47:0] emac_hit_q;
  logic qsat_q;

  // entry tables: valid bits in flops, payload in memories
  logic [ENTRY_SLOTS-1:0] evalid_q;
  logic [31:0] eip_mem [ENTRY_SLOTS];
  logic [47:0] emac_mem [ENTRY_SLOTS];
  logic [15:0] eage_mem [ENTRY_SLOTS];
  logic [31:0] eip_rd_q;
  logic [15:0] eage_rd_q;
  logic [47:0] emac_rd_q;

  logic [REQUEST_SLOTS-1:0] rvalid_q;
  logic [31:0] rip_q [REQUEST_SLOTS];
  logic [3:0]  rtries_q [REQUEST_SLOTS];
  logic [6:0]  rpk_q [REQUEST_SLOTS];

  logic out_v_q;
  acr_pkg::res_t out_q;
  acr_pkg::res_t emit_res;

  logic [EW-1:0] ei;
  logic [RW-1:0] ri;
  logic [RW-1:0] rprev;
  logic [15:0] age_inc;
  assign ei = ei_q[EW-1:0];
  assign ri = ri_q[RW-1:0];
  assign rprev = RW'(ri_q - 1'b1);
  assign age_inc = (eage_rd_q == acr_pkg::AGE_MAX) ? eage_rd_q : eage_rd_q + 16'd1;

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign res.valid = out_v_q;
  assign res.kind = out_q.kind;
  assign res.hit = out_q.hit;
  assign res.full_res = out_q.full_res;
  assign res.result_ip = out_q.result_ip;
  assign res.result_mac = out_q.result_mac;
  assign res.pending_count = out_q.pending_count;
  assign res.last = out_q.last;

  logic out_free;
  logic out_set;
  assign out_free = !out_v_q || res.ready;
  assign out_set = out_free && ((state_q == S_EMIT) ||
                   (state_q == S_TICKR && (ri_q == (RW+1)'(REQUEST_SLOTS) || rvalid_q[ri])));

  // final result of lookup, insert, queue, remove, clear and unknown actions
  always_comb begin
    emit_res = '0;
    emit_res.last = 1'b1;
    emit_res.result_ip = cmd_q.ip_addr;
    case (cmd_q.action)
      acr_pkg::ACT_LOOKUP: begin
        emit_res.kind = acr_pkg::KIND_LOOKUP;
        emit_res.hit = ehit_q;
        emit_res.result_mac = ehit_q ? emac_hit_q : '0;
      end
      acr_pkg::ACT_INSERT: begin
        emit_res.kind = acr_pkg::KIND_INSERT;
        emit_res.hit = rhit_q;
        emit_res.full_res = !(ehit_q || efree_q);
        emit_res.pending_count = rhit_q ? rpk_q[rslot_q] : '0;
      end
      acr_pkg::ACT_QUEUE: begin
        emit_res.kind = acr_pkg::KIND_QUEUE;
        if (rhit_q) begin
          emit_res.full_res = qsat_q;
          emit_res.pending_count = rpk_q[rslot_q];
        end else if (rfree_q) begin
          emit_res.pending_count = rpk_q[rfree_slot_q];
        end else begin
          emit_res.full_res = 1'b1;
        end
      end
      acr_pkg::ACT_REMOVE: emit_res.kind = acr_pkg::KIND_ACK;
      default: begin
        emit_res.kind = acr_pkg::KIND_ACK;
        emit_res.result_ip = '0;
      end
    endcase
  end

  // reads of entry memory, registered; also the tick age and insert payload writes
  always_ff @(posedge clk_i) begin
    eip_rd_q  <= eip_mem[ei];
    eage_rd_q <= eage_mem[ei];
    emac_rd_q <= emac_mem[ei];
    if (state_q == S_ERD && cmd_q.action == acr_pkg::ACT_TICK && evalid_q[ei])
      eage_mem[ei] <= age_inc;
    if (state_q == S_RSCAN && cmd_q.action == acr_pkg::ACT_INSERT &&
        ri_q == '0 && (ehit_q || efree_q)) begin
      eip_mem[ehit_q ? eslot_q : efree_slot_q]  <= cmd_q.ip_addr;
      emac_mem[ehit_q ? eslot_q : efree_slot_q] <= cmd_q.mac_addr;
      eage_mem[ehit_q ? eslot_q : efree_slot_q] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && !empty_i) cmd_q <= cmd_i;
    if (state_q == S_RSCAN && cmd_q.action == acr_pkg::ACT_QUEUE &&
        ri_q == '0 && !rhit_q && rfree_q) begin
      rip_q[rfree_slot_q] <= cmd_q.ip_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      evalid_q <= '0;
      rvalid_q <= '0;
      out_v_q <= 1'b0;
      out_q <= '0;
      ei_q <= '0;
      ri_q <= '0;
      ehit_q <= 1'b0; efree_q <= 1'b0; eslot_q <= '0; efree_slot_q <= '0;
      rhit_q <= 1'b0; rfree_q <= 1'b0; rslot_q <= '0; rfree_slot_q <= '0;
      emac_hit_q <= '0;
      qsat_q <= 1'b0;
      for (int k = 0; k < REQUEST_SLOTS; k++) begin
        rtries_q[k] <= '0;
        rpk_q[k] <= '0;
      end
    end else begin
      if (out_set) out_v_q <= 1'b1;
      else if (res.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            ei_q <= '0; ri_q <= '0;
            ehit_q <= 1'b0; efree_q <= 1'b0;
            rhit_q <= 1'b0; rfree_q <= 1'b0;
            case (cmd_i.action)
              acr_pkg::ACT_LOOKUP, acr_pkg::ACT_INSERT, acr_pkg::ACT_TICK:
                state_q <= S_ESCAN;
              acr_pkg::ACT_QUEUE, acr_pkg::ACT_REMOVE: begin
                ri_q <= (RW+1)'(1);
                state_q <= S_RSCAN;
              end
              default: state_q <= S_EMIT;
            endcase
          end
        end
        // issue read of slot ei
        S_ESCAN: state_q <= S_ERD;
        S_ERD: begin
          if (!ehit_q) eslot_q <= ei;
          if (cmd_q.action == acr_pkg::ACT_TICK) begin
            if (evalid_q[ei] && age_inc > timeout_i) evalid_q[ei] <= 1'b0;
          end else if (evalid_q[ei] && eip_rd_q == cmd_q.ip_addr && !ehit_q) begin
            ehit_q <= 1'b1;
            emac_hit_q <= emac_rd_q;
          end else if (!evalid_q[ei] && !efree_q) begin
            efree_q <= 1'b1;
            efree_slot_q <= ei;
          end
          if (ei_q == (EW+1)'(ENTRY_SLOTS - 1)) begin
            ri_q <= (cmd_q.action == acr_pkg::ACT_INSERT) ? (RW+1)'(1) : '0;
            state_q <= (cmd_q.action == acr_pkg::ACT_LOOKUP) ? S_EMIT :
                       (cmd_q.action == acr_pkg::ACT_INSERT) ? S_RSCAN : S_TICKR;
          end else begin
            ei_q <= ei_q + 1'b1;
            state_q <= S_ESCAN;
          end
        end
        // request search: ri_q counts 1..N, then 0 means commit
        S_RSCAN: begin
          if (ri_q != '0) begin
            if (rvalid_q[rprev] && rip_q[rprev] == cmd_q.ip_addr) begin
              rhit_q <= 1'b1; rslot_q <= rprev;
            end else if (!rvalid_q[rprev] && !rfree_q) begin
              rfree_q <= 1'b1; rfree_slot_q <= rprev;
            end
            ri_q <= (ri_q == (RW+1)'(REQUEST_SLOTS)) ? '0 : ri_q + 1'b1;
          end else begin
            case (cmd_q.action)
              acr_pkg::ACT_INSERT: begin
                if (ehit_q || efree_q) evalid_q[ehit_q ? eslot_q : efree_slot_q] <= 1'b1;
              end
              acr_pkg::ACT_QUEUE: begin
                if (rhit_q) begin
                  qsat_q <= rpk_q[rslot_q] >= MAXP;
                  if (rpk_q[rslot_q] < MAXP) rpk_q[rslot_q] <= rpk_q[rslot_q] + 7'd1;
                  else rpk_q[rslot_q] <= MAXP;
                end else if (rfree_q) begin
                  rvalid_q[rfree_slot_q] <= 1'b1;
                  rtries_q[rfree_slot_q] <= '0;
                  rpk_q[rfree_slot_q] <= 7'd1;
                end
              end
              acr_pkg::ACT_REMOVE: if (rhit_q) rvalid_q[rslot_q] <= 1'b0;
              default: ;
            endcase
            state_q <= S_EMIT;
          end
        end
        S_TICKR: begin
          if (out_free) begin
            if (ri_q == (RW+1)'(REQUEST_SLOTS)) begin
              out_q <= {acr_pkg::KIND_TICK, 1'b0, 1'b0, 32'd0, 48'd0, 7'd0, 1'b1};
              state_q <= S_IDLE;
            end else begin
              if (rvalid_q[ri]) begin
                if (rtries_q[ri] < tries_i) begin
                  out_q <= {acr_pkg::KIND_SEND, 1'b0, 1'b0, rip_q[ri], 48'd0, 7'd0, 1'b0};
                  rtries_q[ri] <= rtries_q[ri] + 4'd1;
                end else begin
                  out_q <= {acr_pkg::KIND_UNREACH, 1'b0, 1'b0, rip_q[ri], 48'd0,
                            rpk_q[ri], 1'b0};
                  rvalid_q[ri] <= 1'b0;
                end
              end
              ri_q <= ri_q + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q <= emit_res;
            if (cmd_q.action == acr_pkg::ACT_CLEAR) begin
              evalid_q <= '0;
              rvalid_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/arp_cache_with_request_retry_core.sv =====
// channel | dir | payload
// cmd     | in  | action, ip_addr, mac_addr
// res     | out | kind, hit, full_res, result_ip, result_mac, pending_count, last
// cfg     | in  | index (0 timeout, 1 tries), data
// Lookup, insert and tick scan the entries slot by slot (a slot read in S_ESCAN
// and a compare in S_ERD through the entry memory port), after dispatch from idle;
// insert, queue and remove then search the request slots and commit, then emit;
// tick walks each request slot and ends with the tick-done result.
// Reset clears all valid bits at once. The back end stalls only on the output
// register; the two-entry queue lets the front keep taking transactions.
module arp_cache_with_request_retry_core #(
  parameter int ENTRY_SLOTS   = 32,
  parameter int REQUEST_SLOTS = 8,
  parameter int MAX_PENDING   = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  acr_cmd_if.sink   cmd,
  acr_res_if.source res,
  acr_cfg_if.sink   cfg
);
  logic push, full, pop, empty;
  acr_pkg::cmd_t fin, fout;
  logic [15:0] timeout_q;
  logic [3:0]  tries_q;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= acr_pkg::TIMEOUT_RESET;
      tries_q <= acr_pkg::TRIES_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == acr_pkg::CFG_TIMEOUT) timeout_q <= cfg.data;
      if (cfg.index == acr_pkg::CFG_TRIES) tries_q <= cfg.data[3:0];
    end
  end

  acr_front u_front (.cmd(cmd), .fifo_full_i(full), .push_o(push), .data_o(fin));

  acr_cmd_fifo u_fifo (.clk_i, .rst_ni, .push_i(push), .data_i(fin), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(fout));

  acr_back #(.ENTRY_SLOTS(ENTRY_SLOTS), .REQUEST_SLOTS(REQUEST_SLOTS),
    .MAX_PENDING(MAX_PENDING)) u_back (.clk_i, .rst_ni, .empty_i(empty),
    .cmd_i(fout), .pop_o(pop), .timeout_i(timeout_q), .tries_i(tries_q), .res(res));
endmodule

// ===== hw/rtl/acr_checker.sv =====
module acr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  res_kind_i,
  input logic        res_hit_i,
  input logic        res_last_i,
  input logic [47:0] res_mac_i
);
  a_tick_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i == acr_pkg::KIND_TICK |-> res_last_i) else $error("tick");
  a_send_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == acr_pkg::KIND_SEND || res_kind_i == acr_pkg::KIND_UNREACH)
    |-> !res_last_i) else $error("send");
  a_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_hit_i |-> res_mac_i == '0) else $error("mac");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i) else $error("hold");
endmodule

bind arp_cache_with_request_retry_core acr_checker u_chk (.clk_i(clk_i),
  .rst_ni(rst_ni), .res_valid_i(res.valid), .res_ready_i(res.ready),
  .res_kind_i(res.kind), .res_hit_i(res.hit), .res_last_i(res.last),
  .res_mac_i(res.result_mac));

// ===== bench/arp_cache_with_request_retry_core_tb.sv =====
`timescale 1ns / 1ps

module arp_cache_with_request_retry_core_tb;

  localparam int N_ENT = 32;
  localparam int N_REQ = 8;
  localparam int PKT_MAX = 64;
  // action codes outside the defined set
  localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  acr_cmd_if cmd ();
  acr_res_if res ();
  acr_cfg_if cfg ();

  arp_cache_with_request_retry_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd   (cmd.sink),
    .res   (res.source),
    .cfg   (cfg.sink)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the resolution and request tables and the config registers
  logic [15:0] sh_timeout;
  logic [3:0]  sh_tries_max;
  logic        ent_ok   [N_ENT];
  logic [31:0] ent_ip   [N_ENT];
  logic [47:0] ent_mac  [N_ENT];
  logic [15:0] ent_age  [N_ENT];
  logic        req_ok   [N_REQ];
  logic [31:0] req_ip   [N_REQ];
  logic [3:0]  req_sent [N_REQ];
  logic [6:0]  req_pkts [N_REQ];

  acr_pkg::res_t answers_q[$];
  int   n_fail = 0;
  bit   hold_off = 0;
  int   stall_pct = 30;
  logic [31:0] ip_pool[8];

  initial begin
    cmd.valid = 1'b0;
    cmd.action = '0;
    cmd.ip_addr = '0;
    cmd.mac_addr = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    res.ready = 1'b0;
  end

  function automatic void push_ans(acr_pkg::kind_e k, logic h, logic f, logic [31:0] ip,
                                   logic [47:0] mac, logic [6:0] cnt);
    acr_pkg::res_t r;
    r.kind = k;
    r.hit = h;
    r.full_res = f;
    r.result_ip = ip;
    r.result_mac = mac;
    r.pending_count = cnt;
    r.last = 1'b0;
    answers_q = {answers_q, r};
  endfunction

  function automatic void predict_table(logic [2:0] act, logic [31:0] ip, logic [47:0] mac);
    int e;
    int r;
    logic f;
    e = -1;
    r = -1;
    f = 1'b0;
    case (act)
      acr_pkg::ACT_LOOKUP: begin
        for (int i = 0; i < N_ENT; i++)
          if (e < 0 && ent_ok[i] && ent_ip[i] == ip) e = i;
        if (e >= 0) push_ans(acr_pkg::KIND_LOOKUP, 1'b1, 1'b0, ip, ent_mac[e], '0);
        else push_ans(acr_pkg::KIND_LOOKUP, 1'b0, 1'b0, ip, '0, '0);
      end
      acr_pkg::ACT_INSERT: begin
        for (int i = 0; i < N_ENT; i++)
          if (e < 0 && ent_ok[i] && ent_ip[i] == ip) e = i;
        if (e < 0)
          for (int i = 0; i < N_ENT; i++)
            if (e < 0 && !ent_ok[i]) e = i;
        if (e >= 0) begin
          ent_ok[e] = 1'b1;
          ent_ip[e] = ip;
          ent_mac[e] = mac;
          ent_age[e] = '0;
        end else f = 1'b1;
        for (int i = 0; i < N_REQ; i++)
          if (r < 0 && req_ok[i] && req_ip[i] == ip) r = i;
        if (r >= 0) push_ans(acr_pkg::KIND_INSERT, 1'b1, f, ip, '0, req_pkts[r]);
        else push_ans(acr_pkg::KIND_INSERT, 1'b0, f, ip, '0, '0);
      end
      acr_pkg::ACT_QUEUE: begin
        for (int i = 0; i < N_REQ; i++)
          if (r < 0 && req_ok[i] && req_ip[i] == ip) r = i;
        if (r < 0) begin
          for (int i = 0; i < N_REQ; i++)
            if (r < 0 && !req_ok[i]) r = i;
          if (r >= 0) begin
            req_ok[r] = 1'b1;
            req_ip[r] = ip;
            req_sent[r] = '0;
            req_pkts[r] = '0;
          end
        end
        if (r < 0) push_ans(acr_pkg::KIND_QUEUE, 1'b0, 1'b1, ip, '0, '0);
        else if (req_pkts[r] >= PKT_MAX) begin
          req_pkts[r] = 7'(PKT_MAX);
          push_ans(acr_pkg::KIND_QUEUE, 1'b0, 1'b1, ip, '0, req_pkts[r]);
        end else begin
          req_pkts[r] = req_pkts[r] + 7'd1;
          push_ans(acr_pkg::KIND_QUEUE, 1'b0, 1'b0, ip, '0, req_pkts[r]);
        end
      end
      acr_pkg::ACT_TICK: begin
        for (int i = 0; i < N_ENT; i++)
          if (ent_ok[i]) begin
            if (ent_age[i] < acr_pkg::AGE_MAX) ent_age[i] = ent_age[i] + 16'd1;
            if (ent_age[i] > sh_timeout) ent_ok[i] = 1'b0;
          end
        for (int i = 0; i < N_REQ; i++)
          if (req_ok[i]) begin
            if (req_sent[i] < sh_tries_max) begin
              req_sent[i] = req_sent[i] + 4'd1;
              push_ans(acr_pkg::KIND_SEND, 1'b0, 1'b0, req_ip[i], '0, '0);
            end else begin
              push_ans(acr_pkg::KIND_UNREACH, 1'b0, 1'b0, req_ip[i], '0, req_pkts[i]);
              req_ok[i] = 1'b0;
            end
          end
        push_ans(acr_pkg::KIND_TICK, 1'b0, 1'b0, '0, '0, '0);
      end
      acr_pkg::ACT_REMOVE: begin
        for (int i = 0; i < N_REQ; i++)
          if (r < 0 && req_ok[i] && req_ip[i] == ip) r = i;
        if (r >= 0) req_ok[r] = 1'b0;
        push_ans(acr_pkg::KIND_ACK, 1'b0, 1'b0, ip, '0, '0);
      end
      acr_pkg::ACT_CLEAR: begin
        for (int i = 0; i < N_ENT; i++) ent_ok[i] = 1'b0;
        for (int i = 0; i < N_REQ; i++) req_ok[i] = 1'b0;
        push_ans(acr_pkg::KIND_ACK, 1'b0, 1'b0, '0, '0, '0);
      end
      default: push_ans(acr_pkg::KIND_ACK, 1'b0, 1'b0, '0, '0, '0);
    endcase
    answers_q[$].last = 1'b1;
  endfunction

  // valid stays high after acceptance so that bursts run back to back
  task automatic send_cmd(logic [2:0] act, logic [31:0] ip, logic [47:0] mac);
    cmd.valid <= 1'b1;
    cmd.action <= act;
    cmd.ip_addr <= ip;
    cmd.mac_addr <= mac;
    do @(posedge clk_i); while (!cmd.ready);
    predict_table(act, ip, mac);
  endtask

  task automatic cmd_idle();
    cmd.valid <= 1'b0;
  endtask

  task automatic burst_gap();
    if ($urandom_range(0, 5) == 0) begin
      cmd_idle();
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    cmd_idle();
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == acr_pkg::CFG_TIMEOUT) sh_timeout = val;
    else sh_tries_max = val[3:0];
    @(posedge clk_i);
  endtask

  // receiver: random stalls, with a long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) res.ready <= 1'b0;
    else if (hold_off) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    acr_pkg::res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (answers_q.size() == 0) begin
        $error("unexpected result kind=%0d ip=%h", res.kind, res.result_ip);
        n_fail++;
      end else begin
        want = answers_q.pop_front();
        if (res.kind !== want.kind) begin
          $error("kind exp %0d got %0d", want.kind, res.kind); n_fail++;
        end
        if (res.hit !== want.hit) begin
          $error("hit exp %0d got %0d", want.hit, res.hit); n_fail++;
        end
        if (res.full_res !== want.full_res) begin
          $error("full_res exp %0d got %0d", want.full_res, res.full_res); n_fail++;
        end
        if (res.result_ip !== want.result_ip) begin
          $error("result_ip exp %h got %h", want.result_ip, res.result_ip); n_fail++;
        end
        if (res.result_mac !== want.result_mac) begin
          $error("result_mac exp %h got %h", want.result_mac, res.result_mac); n_fail++;
        end
        if (res.pending_count !== want.pending_count) begin
          $error("pending_count exp %0d got %0d", want.pending_count, res.pending_count);
          n_fail++;
        end
        if (res.last !== want.last) begin
          $error("last exp %0d got %0d", want.last, res.last); n_fail++;
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(acr_pkg::ACT_LOOKUP, 32'h0, '0);
    send_cmd(acr_pkg::ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_cmd(acr_pkg::ACT_INSERT, 32'h0, 48'h0);
    send_cmd(acr_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, '0);
    send_cmd(acr_pkg::ACT_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
    send_cmd(acr_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_cmd(acr_pkg::ACT_QUEUE, 32'hC0A8_0001, '0);
    send_cmd(acr_pkg::ACT_QUEUE, 32'hC0A8_0001, '0);
    send_cmd(acr_pkg::ACT_INSERT, 32'hC0A8_0001, 48'hAAAA_5555_AAAA);
    send_cmd(acr_pkg::ACT_REMOVE, 32'hDEAD_BEEF, '0);
    send_cmd(acr_pkg::ACT_TICK, '0, '0);
    send_cmd(acr_pkg::ACT_REMOVE, 32'hC0A8_0001, '0);
    send_cmd(ACT_UNDEF_LO, 32'h1111_1111, 48'h1);
    send_cmd(ACT_UNDEF_HI, 32'h2222_2222, 48'h2);
    send_cmd(acr_pkg::ACT_CLEAR, '0, '0);
    send_cmd(acr_pkg::ACT_LOOKUP, 32'h0, '0);
  endtask

  // fill both tables past capacity, saturate a packet count
  task automatic test_full_tables();
    for (int i = 0; i < N_ENT + 2; i++)
      send_cmd(acr_pkg::ACT_INSERT, 32'h0A00_0000 + i, {$urandom, 16'(i)});
    for (int i = 0; i < N_REQ + 1; i++)
      send_cmd(acr_pkg::ACT_QUEUE, 32'h0B00_0000 + i, '0);
    for (int i = 0; i < PKT_MAX + 1; i++) begin
      send_cmd(acr_pkg::ACT_QUEUE, 32'h0B00_0000, '0);
      burst_gap();
    end
    send_cmd(acr_pkg::ACT_TICK, '0, '0);
    send_cmd(acr_pkg::ACT_CLEAR, '0, '0);
  endtask

  // expiry and unreachable at register extremes
  task automatic test_aging(logic [15:0] tmo, logic [3:0] tries, int ticks);
    wait_drained();
    write_reg(acr_pkg::CFG_TIMEOUT, tmo);
    write_reg(acr_pkg::CFG_TRIES, tries);
    send_cmd(acr_pkg::ACT_CLEAR, '0, '0);
    send_cmd(acr_pkg::ACT_INSERT, 32'h0C00_0001, 48'h0102_0304_0506);
    send_cmd(acr_pkg::ACT_QUEUE, 32'h0D00_0001, '0);
    send_cmd(acr_pkg::ACT_QUEUE, 32'h0D00_0002, '0);
    for (int t = 0; t < ticks; t++) begin
      send_cmd(acr_pkg::ACT_TICK, '0, '0);
      send_cmd(acr_pkg::ACT_LOOKUP, 32'h0C00_0001, '0);
    end
  endtask

  task automatic test_random(int n);
    logic [2:0] act;
    logic [31:0] ip;
    for (int i = 0; i < 8; i++) ip_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: act = acr_pkg::ACT_LOOKUP;
        5, 6, 7, 8:    act = acr_pkg::ACT_INSERT;
        9, 10, 11, 12: act = acr_pkg::ACT_QUEUE;
        13, 14, 15:    act = acr_pkg::ACT_TICK;
        16, 17:        act = acr_pkg::ACT_REMOVE;
        18:            act = ($urandom_range(0, 3) == 0) ? acr_pkg::ACT_CLEAR :
                             (($urandom_range(0, 1) == 0) ? ACT_UNDEF_LO : ACT_UNDEF_HI);
        default:       act = acr_pkg::ACT_LOOKUP;
      endcase
      ip = ($urandom_range(0, 4) == 0) ? $urandom : ip_pool[$urandom_range(0, 7)];
      send_cmd(act, ip, {$urandom, 16'($urandom)});
      burst_gap();
    end
  endtask

  // receiver blocked while the sender keeps pushing
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 12; i++)
          send_cmd(acr_pkg::ACT_QUEUE, 32'h0E00_0000 + (i % 4), '0);
        cmd_idle();
      end
    join
    wait_drained();
  endtask

  initial begin
    sh_timeout = acr_pkg::TIMEOUT_RESET;
    sh_tries_max = acr_pkg::TRIES_RESET;
    for (int i = 0; i < N_ENT; i++) ent_ok[i] = 1'b0;
    for (int i = 0; i < N_REQ; i++) req_ok[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_tables();
    test_aging(16'd0, 4'd0, 2);
    test_aging(16'd2, 4'd15, 17);
    test_aging(16'd65535, 4'd1, 3);
    wait_drained();
    write_reg(acr_pkg::CFG_TIMEOUT, 16'd4);
    write_reg(acr_pkg::CFG_TRIES, 4'd3);
    stall_pct = 0;
    test_random(10);
    stall_pct = 50;
    test_random(10);
    test_backpressure();
    wait_drained();
    if (n_fail == 0) $display("arp_cache_with_request_retry_core_tb: PASS");
    else $display("arp_cache_with_request_retry_core_tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("arp_cache_with_request_retry_core_tb: FAIL");
    $finish;
  end

endmodule
